@@ rtl/rmvs_pkg.sv @@
// Package: widths, formats and sequencer states of the running statistics block.
package rmvs_pkg;

   localparam int SAMPLE_BITS    = 20;
   localparam int COUNT_BITS     = 16;
   localparam int MEAN_FRAC_BITS = 16;
   localparam int CPU_BITS       = 8;
   localparam int MIG_BITS       = 16;
   localparam int SUMSQ_BITS     = 62;
   localparam int VAR_BITS       = 46;
   localparam int VAR_FRAC_BITS  = 8;
   localparam int STD_BITS       = 23;

   localparam int MEAN_BITS  = SAMPLE_BITS + MEAN_FRAC_BITS;
   localparam int HALF_BITS  = MEAN_BITS / 2;
   localparam int PROD_BITS  = 2 * MEAN_BITS;
   localparam int PROD_SHIFT = 2 * MEAN_FRAC_BITS - VAR_FRAC_BITS;
   localparam int INC_BITS   = PROD_BITS - PROD_SHIFT;
   localparam int REM_BITS   = STD_BITS + 3;
   localparam int ITER_BITS  = $clog2(SUMSQ_BITS + 1);
   localparam int MUL_STEPS  = 4;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [MIG_BITS-1:0]   MIG_MAX   = '1;
   localparam logic [SUMSQ_BITS-1:0] SUMSQ_MAX = '1;
   localparam logic [VAR_BITS-1:0]   VAR_MAX   = '1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_MEAN,
      ST_MEAN_UPD,
      ST_DEV2,
      ST_MUL,
      ST_SUMSQ,
      ST_VAR_CHK,
      ST_DIV_VAR,
      ST_VAR_SAT,
      ST_SQRT_LOAD,
      ST_SQRT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/rmvs_if.sv @@
// Interfaces: sample channel, statistics channel and initial cpu write channel.
interface rmvs_req_if;
   logic                              valid;
   logic                              ready;
   logic [rmvs_pkg::SAMPLE_BITS-1:0]  sample_usec;
   logic [rmvs_pkg::CPU_BITS-1:0]     cpu_id;
   modport source (output valid, output sample_usec, output cpu_id, input ready);
   modport sink   (input valid, input sample_usec, input cpu_id, output ready);
endinterface

interface rmvs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rmvs_pkg::COUNT_BITS-1:0]   sample_count;
   logic [rmvs_pkg::MEAN_BITS-1:0]    mean_value;
   logic [rmvs_pkg::VAR_BITS-1:0]     variance_value;
   logic [rmvs_pkg::STD_BITS-1:0]     stddev_value;
   logic [rmvs_pkg::SAMPLE_BITS-1:0]  min_value;
   logic [rmvs_pkg::SAMPLE_BITS-1:0]  max_value;
   logic [rmvs_pkg::MIG_BITS-1:0]     migration_count;
   logic                              saturated;
   modport source (output valid, output sample_count, output mean_value,
                   output variance_value, output stddev_value, output min_value,
                   output max_value, output migration_count, output saturated,
                   input ready);
   modport sink   (input valid, input sample_count, input mean_value,
                   input variance_value, input stddev_value, input min_value,
                   input max_value, input migration_count, input saturated,
                   output ready);
endinterface

interface rmvs_csr_if;
   logic                              valid;
   logic                              ready;
   logic [rmvs_pkg::CPU_BITS-1:0]     initial_cpu;
   modport source (output valid, output initial_cpu, input ready);
   modport sink   (input valid, input initial_cpu, output ready);
endinterface

@@ rtl/running_mean_variance_stats.sv @@
// Top level: Welford running mean / variance / stddev with min, max and migration count.
// A new word is taken only in idle, after the previous result is loaded. Steps: accept,
// mean divide, mean update, deviation multiply and add, variance divide, sqrt, load.
// A full count skips the mean path; a count of one skips the variance divide.
// A shared restoring subtract step does both divides and the sqrt. The result waits in an
// output register while the next word runs; an untaken result stalls the final load.
// Synchronous active-high reset clears all statistics; last cpu resets to zero.
module running_mean_variance_stats (
   input  logic        clock,
   input  logic        reset,
   rmvs_req_if.sink    req_ch,
   rmvs_rsp_if.source  rsp_ch,
   rmvs_csr_if.sink    csr_ch
);

   rmvs_pkg::state_type state_ff, state_in;

   logic [rmvs_pkg::COUNT_BITS-1:0]  count_ff;
   logic [rmvs_pkg::MEAN_BITS-1:0]   mean_ff;
   logic [rmvs_pkg::SUMSQ_BITS-1:0]  sumsq_ff;
   logic [rmvs_pkg::SAMPLE_BITS-1:0] min_ff;
   logic [rmvs_pkg::SAMPLE_BITS-1:0] max_ff;
   logic [rmvs_pkg::CPU_BITS-1:0]    last_cpu_ff;
   logic [rmvs_pkg::MIG_BITS-1:0]    mig_ff;
   logic                             rsp_valid_ff;

   logic [rmvs_pkg::SAMPLE_BITS-1:0] x_ff;
   logic                             up_ff;
   logic [rmvs_pkg::MEAN_BITS-1:0]   d1_ff;
   logic [rmvs_pkg::MEAN_BITS-1:0]   d2_ff;
   logic [rmvs_pkg::SUMSQ_BITS-1:0]  src_ff;
   logic [rmvs_pkg::REM_BITS-1:0]    rem_ff;
   logic [rmvs_pkg::SUMSQ_BITS-1:0]  q_ff;
   logic [rmvs_pkg::ITER_BITS-1:0]   iter_ff;
   logic [rmvs_pkg::MEAN_BITS-1:0]   mul_ff;
   logic [1:0]                       mul_sel_ff;
   logic [rmvs_pkg::PROD_BITS-1:0]   acc_ff;
   logic [rmvs_pkg::VAR_BITS-1:0]    var_ff;

   logic [rmvs_pkg::COUNT_BITS-1:0]  rsp_count_ff;
   logic [rmvs_pkg::MEAN_BITS-1:0]   rsp_mean_ff;
   logic [rmvs_pkg::VAR_BITS-1:0]    rsp_var_ff;
   logic [rmvs_pkg::STD_BITS-1:0]    rsp_std_ff;
   logic [rmvs_pkg::SAMPLE_BITS-1:0] rsp_min_ff;
   logic [rmvs_pkg::SAMPLE_BITS-1:0] rsp_max_ff;
   logic [rmvs_pkg::MIG_BITS-1:0]    rsp_mig_ff;
   logic                             rsp_sat_ff;

   // sequencer outputs
   logic req_ready;
   logic accept;
   logic div_step;
   logic sqrt_step;
   logic out_load;
   logic csr_write;

   // datapath
   logic                             active;
   logic [rmvs_pkg::MEAN_BITS-1:0]   xf_new;
   logic [rmvs_pkg::MEAN_BITS-1:0]   xf_cur;
   logic                             up_new;
   logic [rmvs_pkg::MEAN_BITS-1:0]   d1_new;
   logic [rmvs_pkg::REM_BITS-1:0]    rem_shift;
   logic [rmvs_pkg::REM_BITS-1:0]    sub_b;
   logic [rmvs_pkg::REM_BITS:0]      diff;
   logic                             fits;
   logic [rmvs_pkg::MEAN_BITS-1:0]   step;
   logic [rmvs_pkg::MEAN_BITS-1:0]   mul_a;
   logic [rmvs_pkg::MEAN_BITS-1:0]   mul_b;
   logic [rmvs_pkg::PROD_BITS-1:0]   mul_term;
   logic [rmvs_pkg::SUMSQ_BITS:0]    sumsq_sum;
   logic                             iter_last;

   assign active = (count_ff != rmvs_pkg::COUNT_MAX);
   assign xf_new = {req_ch.sample_usec, {rmvs_pkg::MEAN_FRAC_BITS{1'b0}}};
   assign xf_cur = {x_ff, {rmvs_pkg::MEAN_FRAC_BITS{1'b0}}};
   assign up_new = (xf_new >= mean_ff);
   assign d1_new = up_new ? (xf_new - mean_ff) : (mean_ff - xf_new);
   assign iter_last = (iter_ff == '0);
   assign step = q_ff[rmvs_pkg::MEAN_BITS-1:0];

   // shared restoring step: one quotient bit or one root bit per cycle
   always_comb begin
      if (sqrt_step) begin
         rem_shift = {rem_ff[rmvs_pkg::REM_BITS-3:0],
                      src_ff[rmvs_pkg::SUMSQ_BITS-1 -: 2]};
         sub_b     = {1'b0, q_ff[rmvs_pkg::STD_BITS-1:0], 2'b01};
      end else begin
         rem_shift = {rem_ff[rmvs_pkg::REM_BITS-2:0], src_ff[rmvs_pkg::SUMSQ_BITS-1]};
         sub_b     = rmvs_pkg::REM_BITS'(count_ff);
      end
      diff = {1'b0, rem_shift} - {1'b0, sub_b};
      fits = !diff[rmvs_pkg::REM_BITS];
   end

   // partial products of the 36x36 deviation product, 18x18 each
   always_comb begin
      case (iter_ff[1:0])
         2'd0: begin
            mul_a = rmvs_pkg::MEAN_BITS'(d1_ff[rmvs_pkg::HALF_BITS-1:0]);
            mul_b = rmvs_pkg::MEAN_BITS'(d2_ff[rmvs_pkg::HALF_BITS-1:0]);
         end
         2'd1: begin
            mul_a = rmvs_pkg::MEAN_BITS'(d1_ff[rmvs_pkg::HALF_BITS-1:0]);
            mul_b = rmvs_pkg::MEAN_BITS'(d2_ff[rmvs_pkg::MEAN_BITS-1:rmvs_pkg::HALF_BITS]);
         end
         2'd2: begin
            mul_a = rmvs_pkg::MEAN_BITS'(d1_ff[rmvs_pkg::MEAN_BITS-1:rmvs_pkg::HALF_BITS]);
            mul_b = rmvs_pkg::MEAN_BITS'(d2_ff[rmvs_pkg::HALF_BITS-1:0]);
         end
         default: begin
            mul_a = rmvs_pkg::MEAN_BITS'(d1_ff[rmvs_pkg::MEAN_BITS-1:rmvs_pkg::HALF_BITS]);
            mul_b = rmvs_pkg::MEAN_BITS'(d2_ff[rmvs_pkg::MEAN_BITS-1:rmvs_pkg::HALF_BITS]);
         end
      endcase
   end

   always_comb begin
      case (mul_sel_ff) inside
         2'd0:       mul_term = rmvs_pkg::PROD_BITS'(mul_ff);
         2'd1, 2'd2: mul_term = rmvs_pkg::PROD_BITS'(mul_ff) << rmvs_pkg::HALF_BITS;
         default:    mul_term = rmvs_pkg::PROD_BITS'(mul_ff) << rmvs_pkg::MEAN_BITS;
      endcase
   end

   assign sumsq_sum = {1'b0, sumsq_ff}
                    + (rmvs_pkg::SUMSQ_BITS + 1)'(acc_ff[rmvs_pkg::PROD_BITS-1:rmvs_pkg::PROD_SHIFT]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmvs_pkg::ST_IDLE:
            if (req_ch.valid) begin
               state_in = active ? rmvs_pkg::ST_DIV_MEAN : rmvs_pkg::ST_VAR_CHK;
            end
         rmvs_pkg::ST_DIV_MEAN:
            if (iter_last) begin
               state_in = rmvs_pkg::ST_MEAN_UPD;
            end
         rmvs_pkg::ST_MEAN_UPD:  state_in = rmvs_pkg::ST_DEV2;
         rmvs_pkg::ST_DEV2:      state_in = rmvs_pkg::ST_MUL;
         rmvs_pkg::ST_MUL:
            if (iter_ff == rmvs_pkg::ITER_BITS'(rmvs_pkg::MUL_STEPS)) begin
               state_in = rmvs_pkg::ST_SUMSQ;
            end
         rmvs_pkg::ST_SUMSQ:     state_in = rmvs_pkg::ST_VAR_CHK;
         rmvs_pkg::ST_VAR_CHK:
            state_in = (count_ff > rmvs_pkg::COUNT_BITS'(1)) ? rmvs_pkg::ST_DIV_VAR
                                                             : rmvs_pkg::ST_SQRT_LOAD;
         rmvs_pkg::ST_DIV_VAR:
            if (iter_last) begin
               state_in = rmvs_pkg::ST_VAR_SAT;
            end
         rmvs_pkg::ST_VAR_SAT:   state_in = rmvs_pkg::ST_SQRT_LOAD;
         rmvs_pkg::ST_SQRT_LOAD: state_in = rmvs_pkg::ST_SQRT;
         rmvs_pkg::ST_SQRT:
            if (iter_last) begin
               state_in = rmvs_pkg::ST_DONE;
            end
         rmvs_pkg::ST_DONE:
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = rmvs_pkg::ST_IDLE;
            end
         default: state_in = rmvs_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_step  = 1'b0;
      sqrt_step = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         rmvs_pkg::ST_IDLE:     req_ready = 1'b1;
         rmvs_pkg::ST_DIV_MEAN: div_step  = 1'b1;
         rmvs_pkg::ST_DIV_VAR:  div_step  = 1'b1;
         rmvs_pkg::ST_SQRT:     sqrt_step = 1'b1;
         rmvs_pkg::ST_DONE:     out_load  = !rsp_valid_ff || rsp_ch.ready;
         default: ;
      endcase
   end

   assign accept       = req_ch.valid && req_ready;
   assign csr_write    = csr_ch.valid;
   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   // statistics and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmvs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         mean_ff      <= '0;
         sumsq_ff     <= '0;
         min_ff       <= '1;
         max_ff       <= '0;
         last_cpu_ff  <= '0;
         mig_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            if (req_ch.cpu_id != last_cpu_ff) begin
               last_cpu_ff <= req_ch.cpu_id;
               if (mig_ff != rmvs_pkg::MIG_MAX) begin
                  mig_ff <= mig_ff + rmvs_pkg::MIG_BITS'(1);
               end
            end
            if (active) begin
               count_ff <= count_ff + rmvs_pkg::COUNT_BITS'(1);
               if (req_ch.sample_usec < min_ff) begin
                  min_ff <= req_ch.sample_usec;
               end
               if (req_ch.sample_usec > max_ff) begin
                  max_ff <= req_ch.sample_usec;
               end
            end
         end else if (csr_write && count_ff == '0) begin
            last_cpu_ff <= csr_ch.initial_cpu;
         end
         if (state_ff == rmvs_pkg::ST_MEAN_UPD) begin
            mean_ff <= up_ff ? (mean_ff + step) : (mean_ff - step);
         end
         if (state_ff == rmvs_pkg::ST_SUMSQ) begin
            sumsq_ff <= sumsq_sum[rmvs_pkg::SUMSQ_BITS] ? rmvs_pkg::SUMSQ_MAX
                                                        : sumsq_sum[rmvs_pkg::SUMSQ_BITS-1:0];
         end
      end
   end

   // working registers of the shared unit
   always_ff @(posedge clock) begin
      if (div_step || sqrt_step) begin
         rem_ff  <= fits ? diff[rmvs_pkg::REM_BITS-1:0] : rem_shift;
         q_ff    <= {q_ff[rmvs_pkg::SUMSQ_BITS-2:0], fits};
         src_ff  <= sqrt_step ? (src_ff << 2) : (src_ff << 1);
         iter_ff <= iter_ff - rmvs_pkg::ITER_BITS'(1);
      end
      unique case (state_ff)
         rmvs_pkg::ST_IDLE:
            if (accept) begin
               x_ff    <= req_ch.sample_usec;
               up_ff   <= up_new;
               d1_ff   <= d1_new;
               src_ff  <= {d1_new, {(rmvs_pkg::SUMSQ_BITS - rmvs_pkg::MEAN_BITS){1'b0}}};
               rem_ff  <= '0;
               q_ff    <= '0;
               iter_ff <= rmvs_pkg::ITER_BITS'(rmvs_pkg::MEAN_BITS - 1);
            end
         rmvs_pkg::ST_DEV2: begin
            d2_ff   <= up_ff ? (xf_cur - mean_ff) : (mean_ff - xf_cur);
            acc_ff  <= '0;
            iter_ff <= '0;
         end
         rmvs_pkg::ST_MUL: begin
            if (iter_ff != rmvs_pkg::ITER_BITS'(rmvs_pkg::MUL_STEPS)) begin
               mul_ff     <= mul_a * mul_b;
               mul_sel_ff <= iter_ff[1:0];
            end
            if (iter_ff != '0) begin
               acc_ff <= acc_ff + mul_term;
            end
            iter_ff <= iter_ff + rmvs_pkg::ITER_BITS'(1);
         end
         rmvs_pkg::ST_VAR_CHK: begin
            src_ff  <= sumsq_ff;
            rem_ff  <= '0;
            q_ff    <= '0;
            iter_ff <= rmvs_pkg::ITER_BITS'(rmvs_pkg::SUMSQ_BITS - 1);
            var_ff  <= '0;
         end
         rmvs_pkg::ST_VAR_SAT:
            var_ff <= (q_ff[rmvs_pkg::SUMSQ_BITS-1:rmvs_pkg::VAR_BITS] != '0)
                      ? rmvs_pkg::VAR_MAX : q_ff[rmvs_pkg::VAR_BITS-1:0];
         rmvs_pkg::ST_SQRT_LOAD: begin
            src_ff  <= {var_ff, {(rmvs_pkg::SUMSQ_BITS - rmvs_pkg::VAR_BITS){1'b0}}};
            rem_ff  <= '0;
            q_ff    <= '0;
            iter_ff <= rmvs_pkg::ITER_BITS'(rmvs_pkg::STD_BITS - 1);
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_count_ff <= count_ff;
         rsp_mean_ff  <= mean_ff;
         rsp_var_ff   <= var_ff;
         rsp_std_ff   <= q_ff[rmvs_pkg::STD_BITS-1:0];
         rsp_min_ff   <= min_ff;
         rsp_max_ff   <= max_ff;
         rsp_mig_ff   <= mig_ff;
         rsp_sat_ff   <= (count_ff == rmvs_pkg::COUNT_MAX);
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.sample_count    = rsp_count_ff;
   assign rsp_ch.mean_value      = rsp_mean_ff;
   assign rsp_ch.variance_value  = rsp_var_ff;
   assign rsp_ch.stddev_value    = rsp_std_ff;
   assign rsp_ch.min_value       = rsp_min_ff;
   assign rsp_ch.max_value       = rsp_max_ff;
   assign rsp_ch.migration_count = rsp_mig_ff;
   assign rsp_ch.saturated       = rsp_sat_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != rmvs_pkg::ST_IDLE)
      else $error("sequencer stayed idle after accepting a word");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmvs_pkg::ST_DIV_MEAN || state_ff == rmvs_pkg::ST_DIV_VAR)
      |-> count_ff != '0)
      else $error("divide started with zero count");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> min_ff <= max_ff)
      else $error("min above max");

   a_mig_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> mig_ff >= $past(mig_ff))
      else $error("migration count went down");

   a_result_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !out_load)
      else $error("result register reloaded while a word was stalled");

endmodule
